// ===== hdl/hpq_pkg.sv =====
// Package for the binary max-heap priority queue.
// Holds the default heap depth, fixed field widths and result status codes.
// No dependencies.
`default_nettype none

package hpq_pkg;

	localparam int HEAP_DEPTH_DEF = 64;
	localparam int VALUE_W        = 32;
	localparam int COUNT_W        = 7;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

`default_nettype wire

// ===== hdl/max_heap_priority_queue.sv =====
// Binary max-heap priority queue of signed 32-bit values over one on-chip array.
// Depends on hpq_pkg for widths and status codes.
//
// An insert (mode 0) stays busy for a read and a compare of each parent it checks,
// plus a final read when it climbs to the root. An extract (mode 1) stays busy for
// a load of the last entry, a read and a compare for each level it moves down, then
// a final read, plus a compare when it stops above a leaf. A one-write, two-read heap
// array serves every level: each level needs a registered read and then a compare
// and write. An insert into a full heap, an extract from an empty heap and an extract
// of the only entry never raise busy. The result shows in the same cycle that busy
// falls, for exactly one cycle with done high, and the receiver cannot hold it off.
`default_nettype none

module max_heap_priority_queue import hpq_pkg::*; #(
	parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      mode,
	input  wire logic signed [VALUE_W-1:0] value_in,
	output logic                           done,
	output logic signed [VALUE_W-1:0]      value_out,
	output logic [1:0]                     status,
	output logic signed [VALUE_W-1:0]      top_value,
	output logic                           is_empty,
	output logic [COUNT_W-1:0]             entry_count
);

	localparam int ADDR_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
	localparam int IDX_W  = ADDR_W + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_LOAD,
		S_DN_RD,
		S_DN_CMP
	} state_t;

	state_t                      state_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [ADDR_W-1:0]           idx_q;
	logic signed [VALUE_W-1:0]   v_q;
	logic signed [VALUE_W-1:0]   top_q;
	logic                        done_q;
	logic signed [VALUE_W-1:0]   vout_q;
	status_t                     status_q;

	logic [VALUE_W-1:0]          mem [HEAP_DEPTH];
	logic signed [VALUE_W-1:0]   rd_a_q;
	logic signed [VALUE_W-1:0]   rd_b_q;

	logic                        we;
	logic [ADDR_W-1:0]           waddr;
	logic signed [VALUE_W-1:0]   wdata;
	logic [ADDR_W-1:0]           ra_addr;
	logic [ADDR_W-1:0]           rb_addr;
	logic                        finish;

	logic                        accept;
	logic [ADDR_W-1:0]           par;
	logic [IDX_W-1:0]            lchild;
	logic [IDX_W-1:0]            rchild;
	logic [IDX_W-1:0]            cnt_x;
	logic                        take_r;
	logic signed [VALUE_W-1:0]   big_val;
	logic [ADDR_W-1:0]           big_idx;
	logic [CNT_W+COUNT_W-1:0]    cnt_ext;

	assign accept  = start && (state_q == S_IDLE);
	assign par     = ADDR_W'((idx_q - ADDR_W'(1)) >> 1);
	assign lchild  = {idx_q, 1'b1};
	assign rchild  = lchild + IDX_W'(1);
	assign cnt_x   = IDX_W'(cnt_q);
	assign take_r  = (rchild < cnt_x) && (rd_b_q > rd_a_q);
	assign big_val = take_r ? rd_b_q : rd_a_q;
	assign big_idx = take_r ? rchild[ADDR_W-1:0] : lchild[ADDR_W-1:0];

	always_comb begin
		we      = 1'b0;
		waddr   = idx_q;
		wdata   = v_q;
		ra_addr = ADDR_W'(cnt_q - CNT_W'(1));
		rb_addr = rchild[ADDR_W-1:0];
		finish  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_UP_RD: begin
				ra_addr = par;
				if (idx_q == '0) begin
					we     = 1'b1;
					finish = 1'b1;
				end
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (v_q > rd_a_q) begin
					wdata = rd_a_q;
				end else begin
					finish = 1'b1;
				end
			end
			S_DN_LOAD: begin
			end
			S_DN_RD: begin
				ra_addr = lchild[ADDR_W-1:0];
				if (lchild >= cnt_x) begin
					we     = 1'b1;
					finish = 1'b1;
				end
			end
			S_DN_CMP: begin
				we = 1'b1;
				if (big_val > v_q) begin
					wdata = big_val;
				end else begin
					finish = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rd_a_q <= mem[ra_addr];
		rd_b_q <= mem[rb_addr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			top_q    <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			vout_q   <= '0;
			idx_q    <= '0;
			v_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (we && waddr == '0) begin
				top_q <= wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						vout_q   <= '0;
						status_q <= ST_OK;
						if (!mode) begin
							if (cnt_q >= CNT_W'(HEAP_DEPTH)) begin
								status_q <= ST_FULL;
								done_q   <= 1'b1;
							end else begin
								idx_q   <= cnt_q[ADDR_W-1:0];
								v_q     <= value_in;
								cnt_q   <= cnt_q + CNT_W'(1);
								state_q <= S_UP_RD;
							end
						end else begin
							if (cnt_q == '0) begin
								status_q <= ST_EMPTY;
								done_q   <= 1'b1;
							end else begin
								vout_q <= top_q;
								cnt_q  <= cnt_q - CNT_W'(1);
								if (cnt_q == CNT_W'(1)) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_DN_LOAD;
								end
							end
						end
					end
				end
				S_UP_RD: begin
					state_q <= finish ? S_IDLE : S_UP_CMP;
					done_q  <= finish;
				end
				S_UP_CMP: begin
					if (finish) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						idx_q   <= par;
						state_q <= S_UP_RD;
					end
				end
				S_DN_LOAD: begin
					v_q     <= rd_a_q;
					idx_q   <= '0;
					state_q <= S_DN_RD;
				end
				S_DN_RD: begin
					state_q <= finish ? S_IDLE : S_DN_CMP;
					done_q  <= finish;
				end
				S_DN_CMP: begin
					if (finish) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						idx_q   <= big_idx;
						state_q <= S_DN_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cnt_ext     = {{COUNT_W{1'b0}}, cnt_q};
	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign value_out   = vout_q;
	assign status      = status_q;
	assign is_empty    = (cnt_q == '0);
	assign top_value   = (cnt_q == '0) ? '0 : top_q;
	assign entry_count = cnt_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/hpq_checker.sv =====
// Port-level checker for the max-heap priority queue, bound to the top level.
// Depends on hpq_pkg for widths and status codes.
`default_nettype none

module hpq_checker import hpq_pkg::*; (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      start,
	input wire logic                      busy,
	input wire logic                      done,
	input wire logic signed [VALUE_W-1:0] value_out,
	input wire logic [1:0]                status,
	input wire logic signed [VALUE_W-1:0] top_value,
	input wire logic                      is_empty
);

	property p_transfer_makes_progress;
		@(posedge clk) disable iff (!arst_n) (start && !busy) |=> (busy || done);
	endproperty
	a_transfer_makes_progress: assert property (p_transfer_makes_progress)
		else $error("accepted transfer neither busy nor done");

	property p_done_not_busy;
		@(posedge clk) disable iff (!arst_n) done |-> !busy;
	endproperty
	a_done_not_busy: assert property (p_done_not_busy)
		else $error("result shown while busy");

	property p_empty_top_zero;
		@(posedge clk) disable iff (!arst_n) (done && is_empty) |-> (top_value == '0);
	endproperty
	a_empty_top_zero: assert property (p_empty_top_zero)
		else $error("empty heap reports nonzero top");

	property p_empty_status;
		@(posedge clk) disable iff (!arst_n)
			(done && status == ST_EMPTY) |-> (value_out == '0 && is_empty);
	endproperty
	a_empty_status: assert property (p_empty_status)
		else $error("empty status with data or stored entries");

	property p_full_status;
		@(posedge clk) disable iff (!arst_n)
			(done && status == ST_FULL) |-> (value_out == '0 && !is_empty);
	endproperty
	a_full_status: assert property (p_full_status)
		else $error("full status with data or empty heap");

endmodule

bind max_heap_priority_queue hpq_checker u_hpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.value_out (value_out),
	.status    (status),
	.top_value (top_value),
	.is_empty  (is_empty)
);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the binary max-heap priority queue.
// Holds a heap scoreboard class that predicts every result, plus the driving task.
// Depends on hpq_pkg and the max_heap_priority_queue RTL.
`default_nettype none

module tb;
	import hpq_pkg::*;

	localparam int   DEPTH        = HEAP_DEPTH_DEF;
	localparam int   RANDOM_ITEMS = 1600;
	localparam int   MAX_GAP      = 40;
	localparam int   STALL_LIMIT  = 1000;
	localparam int   TAIL_CYCLES  = 32;
	localparam int   MAX_REPORTS  = 10;
	localparam logic MODE_INSERT  = 1'b0;
	localparam logic MODE_EXTRACT = 1'b1;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		status_t                   status;
		logic signed [VALUE_W-1:0] top;
		logic                      empty;
		logic [COUNT_W-1:0]        count;
	} heap_result_t;

	class heap_scoreboard;
		logic signed [VALUE_W-1:0] store [DEPTH];
		int                        fill;
		heap_result_t              due[$];
		int                        mismatches;
		int                        n_checked;
		int                        n_insert;
		int                        n_extract;
		int                        n_full;
		int                        n_empty;

		function new();
			fill       = 0;
			mismatches = 0;
			n_checked  = 0;
			n_insert   = 0;
			n_extract  = 0;
			n_full     = 0;
			n_empty    = 0;
		endfunction

		function void swap_entries(int a, int b);
			logic signed [VALUE_W-1:0] t;
			t        = store[a];
			store[a] = store[b];
			store[b] = t;
		endfunction

		function void note_transfer(logic m, logic signed [VALUE_W-1:0] v);
			heap_result_t r;
			int           idx;
			int           par;
			int           lft;
			int           big;
			r.value  = '0;
			r.status = ST_OK;
			if (m == MODE_INSERT) begin
				n_insert++;
				if (fill >= DEPTH) begin
					r.status = ST_FULL;
					n_full++;
				end else begin
					store[fill] = v;
					idx         = fill;
					fill++;
					while (idx > 0) begin
						par = (idx - 1) / 2;
						if (!(store[idx] > store[par]))
							break;
						swap_entries(idx, par);
						idx = par;
					end
				end
			end else begin
				n_extract++;
				if (fill == 0) begin
					r.status = ST_EMPTY;
					n_empty++;
				end else begin
					r.value  = store[0];
					fill--;
					store[0] = store[fill];
					idx      = 0;
					while (1) begin
						lft = 2 * idx + 1;
						if (lft >= fill)
							break;
						big = lft;
						if (lft + 1 < fill && store[lft + 1] > store[lft])
							big = lft + 1;
						if (!(store[big] > store[idx]))
							break;
						swap_entries(idx, big);
						idx = big;
					end
				end
			end
			r.top   = (fill != 0) ? store[0] : '0;
			r.empty = (fill == 0);
			r.count = fill[COUNT_W-1:0];
			due     = {due, r};
		endfunction

		function void check_result(logic signed [VALUE_W-1:0] v, logic [1:0] st,
				logic signed [VALUE_W-1:0] top, logic emp, logic [COUNT_W-1:0] cnt);
			heap_result_t r;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display({"unexpected result: value %0d status %0d top %0d",
						" empty %0d count %0d"}, v, st, top, emp, cnt);
				return;
			end
			r = due.pop_front();
			n_checked++;
			if (v !== r.value || st !== r.status || top !== r.top || emp !== r.empty ||
					cnt !== r.count) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("mismatch on result %0d:", n_checked);
					$display("  expected value %0d status %0d top %0d empty %0d count %0d",
						r.value, r.status, r.top, r.empty, r.count);
					$display("  actual   value %0d status %0d top %0d empty %0d count %0d",
						v, st, top, emp, cnt);
				end
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic                      mode;
	logic signed [VALUE_W-1:0] value_in;
	logic                      done;
	logic signed [VALUE_W-1:0] value_out;
	logic [1:0]                status;
	logic signed [VALUE_W-1:0] top_value;
	logic                      is_empty;
	logic [COUNT_W-1:0]        entry_count;

	heap_scoreboard sb;
	int             quiet_cycles;

	max_heap_priority_queue #(
		.HEAP_DEPTH(DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.value_in   (value_in),
		.done       (done),
		.value_out  (value_out),
		.status     (status),
		.top_value  (top_value),
		.is_empty   (is_empty),
		.entry_count(entry_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_transfer(mode, value_in);
			if (done)
				sb.check_result(value_out, status, top_value, is_empty, entry_count);
		end
		if ((arst_n && start && !busy) || (arst_n && done))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(3))
			0: return $urandom_range(8) - 4;
			1: begin
				case ($urandom_range(3))
					0: return 32'sh7FFFFFFF;
					1: return 32'sh80000000;
					2: return 32'sh0;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input logic m, input logic signed [VALUE_W-1:0] v,
			input int idle_pct);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
			start    <= 1'b0;
			mode     <= 1'($urandom);
			value_in <= $urandom;
			@(negedge clk);
			gap++;
		end
		start    <= 1'b1;
		mode     <= m;
		value_in <= v;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	initial begin
		int sent;
		int burst;
		int len;
		int k;
		int ins_pct;
		int idle;
		sb           = new();
		quiet_cycles = 0;
		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		mode         = MODE_INSERT;
		value_in     = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(MODE_EXTRACT, 32'sh5A5A5A5A, 0);
		send_item(MODE_INSERT, 32'sh0, 0);
		send_item(MODE_INSERT, 32'sh7FFFFFFF, 0);
		send_item(MODE_INSERT, 32'sh80000000, 0);
		send_item(MODE_INSERT, -32'sd1, 0);
		send_item(MODE_INSERT, 32'sd1, 0);
		send_item(MODE_INSERT, 32'sd5, 0);
		send_item(MODE_INSERT, 32'sd5, 0);
		send_item(MODE_INSERT, 32'sd5, 0);
		repeat (9)
			send_item(MODE_EXTRACT, $urandom, 0);
		send_item(MODE_INSERT, 32'sd9, 0);
		send_item(MODE_INSERT, 32'sd4, 0);
		send_item(MODE_INSERT, 32'sd4, 0);
		send_item(MODE_INSERT, 32'sd1, 0);
		send_item(MODE_EXTRACT, 32'shFFFFFFFF, 0);

		sent  = 0;
		burst = 0;
		while (sent < RANDOM_ITEMS) begin
			case (burst % 3)
				0: ins_pct = 92;
				1: ins_pct = 50;
				default: ins_pct = 10;
			endcase
			case ($urandom_range(3))
				1: idle = 76;
				2: idle = 13;
				default: idle = 0;
			endcase
			len = $urandom_range(160, 90);
			for (k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
				if ($urandom_range(99) < ins_pct)
					send_item(MODE_INSERT, pick_value(), idle);
				else
					send_item(MODE_EXTRACT, $urandom, idle);
				sent++;
			end
			burst++;
		end
		start <= 1'b0;

		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display({"run covered %0d inserts (%0d into a full heap) and %0d extracts",
			" (%0d from an empty heap)"}, sb.n_insert, sb.n_full, sb.n_extract, sb.n_empty);
		$display("%0d results checked, %0d mismatches", sb.n_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/hpq_pkg.sv
hdl/max_heap_priority_queue.sv
hdl/hpq_checker.sv
dv/tb.sv
